/* rtl/ohc_pkg.sv */
// Shared types and constants for the open-address hash counter.
package ohc_pkg;

   localparam int KEY_W  = 64;
   localparam int FREQ_W = 32;
   localparam int PROBE_W = 11;
   localparam int STAT_W = 3;
   localparam int CFG_CAP_W = 11;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [STAT_W-1:0] STATUS_HIT   = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_NEW   = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_MISS  = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE    = 8'd1;

   localparam logic [CFG_CAP_W-1:0] CAP_RESET = 11'd1024;
   localparam logic [FREQ_W-1:0]    FREQ_MAX  = 32'hFFFF_FFFF;

   localparam logic PROBE_LINEAR = 1'b0;

   typedef struct packed {
      logic             mode;
      logic [KEY_W-1:0] key_chars;
   } req_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  frequency;
      logic [PROBE_W-1:0] probe_count;
      logic [STAT_W-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic hash;
      logic div;
      logic read;
      logic check;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic key_empty;
      logic hash_last;
      logic div_last;
      logic walk_done;
      logic clear_last;
   } stat_type;

endpackage

/* rtl/ohc_ctrl.sv */
// Sequencer for the hash counter: clear, hash, divide, probe, respond.
module ohc_ctrl
   import ohc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_DIV, S_READ, S_CHECK, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (st.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = st.key_empty ? S_RESP : S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash = 1'b1;
            if (st.hash_last) state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div = 1'b1;
            if (st.div_last) state_in = S_READ;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = st.walk_done ? S_RESP : S_READ;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/ohc_dp.sv */
// Datapath: config registers, key hashing, remainder unit, table memory.
module ohc_dp
   import ohc_pkg::*;
#(
   parameter int SLOTS     = 1024,
   parameter int KEY_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  cmd_type               cmd,
   output stat_type              st
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [CFG_CAP_W-1:0] cfg_cap_ff;
   logic                 cfg_method_ff;

   logic                 mode_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [3:0]           len_ff;
   logic [2:0]           idx_ff;
   logic [31:0]          hash_ff;
   logic [4:0]           div_cnt_ff;
   logic [CW-1:0]        rem_a_ff, rem_b_ff;
   logic [CW-1:0]        cap_ff;
   logic                 method_ff;
   logic [SW-1:0]        slot_ff;
   logic [CW-1:0]        step_ff;
   logic [CW-1:0]        coll_ff;
   logic [SW-1:0]        clr_ff;
   logic [KEY_W-1:0]     key_rd_ff;
   logic [FREQ_W-1:0]    cnt_rd_ff;
   rsp_type              res_ff, rsp_ff;

   logic [KEY_W-1:0]     key_mem [SLOTS];
   logic [FREQ_W-1:0]    cnt_mem [SLOTS];

   // key normalization at accept
   logic [KEY_W-1:0]     norm_key;
   logic [3:0]           norm_len;
   logic                 alive;
   logic [CW-1:0]        cap_clamp;

   always_comb begin
      norm_key = '0;
      norm_len = '0;
      alive    = 1'b1;
      for (int i = 0; i < 8; i++) begin
         alive = alive && (req_data.key_chars[8*i +: 8] != 8'd0) && (i < KEY_BYTES);
         if (alive) begin
            norm_key[8*i +: 8] = req_data.key_chars[8*i +: 8];
            norm_len = norm_len + 4'd1;
         end
      end
   end

   always_comb begin
      if (cfg_cap_ff < CFG_CAP_W'(2)) cap_clamp = CW'(2);
      else if (32'(cfg_cap_ff) > 32'(SLOTS)) cap_clamp = CW'(SLOTS);
      else cap_clamp = CW'(cfg_cap_ff);
   end

   // remainder unit: restoring, one dividend bit per cycle, two divisors
   logic [CW:0]   trial_a, trial_b;
   logic [CW-1:0] rem_a_in, rem_b_in;
   logic [CW-1:0] cap_m1;

   assign cap_m1  = cap_ff - CW'(1);
   assign trial_a = {rem_a_ff, hash_ff[31]};
   assign trial_b = {rem_b_ff, hash_ff[31]};
   assign rem_a_in = (trial_a >= {1'b0, cap_ff}) ? CW'(trial_a - {1'b0, cap_ff})
                                                 : CW'(trial_a);
   assign rem_b_in = (trial_b >= {1'b0, cap_m1}) ? CW'(trial_b - {1'b0, cap_m1})
                                                 : CW'(trial_b);

   // probe step
   logic          hit, vacant, exhausted, sat;
   logic [CW-1:0] coll_inc;
   logic [CW:0]   slot_sum;
   logic [SW-1:0] slot_adv;
   logic [FREQ_W-1:0] cnt_new;
   logic          mem_we;
   rsp_type       res_chk;

   assign hit       = (key_rd_ff == key_ff);
   assign vacant    = (key_rd_ff == '0);
   assign coll_inc  = coll_ff + CW'(1);
   assign exhausted = !hit && !vacant && (coll_inc >= cap_ff);
   assign sat       = (cnt_rd_ff == FREQ_MAX);
   assign cnt_new   = (mode_ff && !sat) ? cnt_rd_ff + FREQ_W'(1) : cnt_rd_ff;
   assign mem_we    = cmd.check && mode_ff && ((hit && !sat) || vacant);

   always_comb begin
      if (method_ff == PROBE_LINEAR) slot_sum = {1'b0, CW'(slot_ff)} + (CW+1)'(1);
      else                           slot_sum = {1'b0, CW'(slot_ff)} + {1'b0, step_ff};
      // wrap by subtracting the capacity; linear probing lands on slot zero
      if (slot_sum >= {1'b0, cap_ff}) slot_adv = SW'(slot_sum - {1'b0, cap_ff});
      else slot_adv = SW'(slot_sum);
   end

   always_comb begin
      res_chk.frequency   = '0;
      res_chk.probe_count = PROBE_W'(coll_ff);
      res_chk.status      = STATUS_MISS;
      if (hit) begin
         res_chk.frequency = cnt_new;
         res_chk.status    = STATUS_HIT;
      end else if (vacant) begin
         if (mode_ff) begin
            res_chk.frequency = FREQ_W'(1);
            res_chk.status    = STATUS_NEW;
         end
      end else begin
         res_chk.probe_count = PROBE_W'(coll_inc);
         if (mode_ff) res_chk.status = STATUS_FULL;
      end
   end

   assign st.key_empty  = (norm_len == 4'd0);
   assign st.hash_last  = ({1'b0, idx_ff} + 4'd1 == len_ff);
   assign st.div_last   = (div_cnt_ff == 5'd31);
   assign st.walk_done  = hit || vacant || exhausted;
   assign st.clear_last = (clr_ff == SW'(SLOTS - 1));
   assign rsp_data      = rsp_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cap_ff    <= CAP_RESET;
         cfg_method_ff <= PROBE_LINEAR;
      end else if (csr_valid) begin
         if (csr_index == CSR_CAPACITY) cfg_cap_ff <= csr_data[CFG_CAP_W-1:0];
         else if (csr_index == CSR_PROBE) cfg_method_ff <= csr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_ff + SW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_data.mode;
         key_ff     <= norm_key;
         len_ff     <= norm_len;
         idx_ff     <= '0;
         hash_ff    <= '0;
         div_cnt_ff <= '0;
         rem_a_ff   <= '0;
         rem_b_ff   <= '0;
         cap_ff     <= cap_clamp;
         method_ff  <= cfg_method_ff;
         coll_ff    <= '0;
         res_ff     <= '{frequency: '0, probe_count: '0, status: STATUS_EMPTY};
      end
      if (cmd.hash) begin
         hash_ff <= 32'(key_ff[8*idx_ff +: 8]) + (hash_ff << 5) - hash_ff;
         idx_ff  <= idx_ff + 3'd1;
      end
      if (cmd.div) begin
         rem_a_ff   <= rem_a_in;
         rem_b_ff   <= rem_b_in;
         hash_ff    <= hash_ff << 1;
         div_cnt_ff <= div_cnt_ff + 5'd1;
         if (st.div_last) begin
            slot_ff <= SW'(rem_a_in);
            step_ff <= rem_b_in + CW'(1);
         end
      end
      if (cmd.check) begin
         if (st.walk_done) res_ff <= res_chk;
         else begin
            coll_ff <= coll_inc;
            slot_ff <= slot_adv;
         end
      end
      if (cmd.publish) rsp_ff <= res_ff;
   end

   // table memory: one read, one write port
   always_ff @(posedge clock) begin
      if (cmd.read) key_rd_ff <= key_mem[slot_ff];
      if (cmd.clear) key_mem[clr_ff] <= '0;
      else if (mem_we) key_mem[slot_ff] <= key_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.read) cnt_rd_ff <= cnt_mem[slot_ff];
      if (mem_we) cnt_mem[slot_ff] <= hit ? cnt_new : FREQ_W'(1);
   end

endmodule

/* rtl/open_address_hash_counter.sv */
// Top level of the open-address hash counter: sequencer plus datapath.
//
// Counts occurrences of short keys (up to eight characters, low byte first,
// ending at the first zero byte) in an open-addressed table of SLOTS entries.
// A request either looks a key up (mode 0) or inserts it / bumps its count
// (mode 1, saturating); every request gives exactly one response carrying the
// count, the number of collisions passed and a status code. After reset the
// table is swept clear, one slot per cycle, and no request is taken meanwhile;
// configuration writes are taken at any time and must only be issued while
// the block is idle. One request is handled at a time: the key is hashed with
// one hash step per character, then a bit-serial remainder unit over the
// 32-bit hash yields the home slot and the double-hashing step together, then
// the table is probed, each probe costing one registered memory read and one
// compare. A finished response sits in an output register, so the next
// request is accepted while it waits to be taken.
module open_address_hash_counter
   import ohc_pkg::*;
#(
   parameter int SLOTS     = 1024,
   parameter int KEY_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type st;

   // config registers never stall
   assign csr_ready = 1'b1;

   ohc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   ohc_dp #(
      .SLOTS     (SLOTS),
      .KEY_BYTES (KEY_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .st        (st)
   );

endmodule
